[rtl/mfre_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfre_pkg: shared constants and types of the mono framebuffer raster engine
// screen geometry, command codes and the controller/datapath interface
// ----------------------------------------------------------------------------
package mfre_pkg;

  localparam int SCREEN_W    = 240;
  localparam int SCREEN_H    = 320;
  localparam int ROW_BYTES   = 30;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;

  // drawable width, pixels beyond the last row byte are never written
  localparam int DRAW_W = (SCREEN_W < ROW_BYTES * 8) ? SCREEN_W : ROW_BYTES * 8;

  localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int XW  = $clog2(DRAW_W);
  localparam int YW  = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
  localparam int BXW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int CW  = 13;  // signed coordinate arithmetic

  localparam logic signed [CW-1:0] DRAW_WS   = CW'(DRAW_W);
  localparam logic signed [CW-1:0] SCREEN_HS = CW'(SCREEN_H);

  localparam logic [2:0] CMD_FILL    = 3'd0;
  localparam logic [2:0] CMD_OUTLINE = 3'd1;
  localparam logic [2:0] CMD_BLIT    = 3'd2;
  localparam logic [2:0] CMD_IMAGE   = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // rectangle segment selection
  localparam logic [2:0] SEG_FULL  = 3'd0;
  localparam logic [2:0] SEG_TOP   = 3'd1;
  localparam logic [2:0] SEG_BOT   = 3'd2;
  localparam logic [2:0] SEG_LEFT  = 3'd3;
  localparam logic [2:0] SEG_RIGHT = 3'd4;

  // memory address source
  localparam logic [1:0] SRC_RECT = 2'd0;
  localparam logic [1:0] SRC_BLA  = 2'd1;
  localparam logic [1:0] SRC_BLB  = 2'd2;
  localparam logic [1:0] SRC_READ = 2'd3;

  typedef struct packed {
    logic       item_load;
    logic       rect_load;
    logic [2:0] seg;
    logic       rect_prep;
    logic       rect_adv;
    logic       blit_start;
    logic       blit_prep;
    logic       blit_upd;
    logic       clr_start;
    logic       clr_step;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] src;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] item_cmd;
    logic       rect_empty;
    logic       rect_last;
    logic       clr_last;
    logic       blit_pending;
    logic       mask_a_nz;
    logic       mask_b_nz;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/mono_framebuffer_raster_engine_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine_core: 1bpp framebuffer drawing engine
// fill, outline, blit, clear and byte read-back over a packed byte store
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | cmd, pos_x, pos_y, width, height, color,
//          |                     | mode, image_byte, read_addr
//  out     | out_valid/out_stall | read_data, one per read request
//
// one request at a time; in_stall is high whenever the sequencer is busy
// every request is taken in the idle state and then decoded in the decode state
// fill/outline: each touched framebuffer byte is read then written, and each
//   rectangle adds a prep and a segment step; an outline is four rectangles
// image byte: a prep step, up to two byte read-modify-writes and an update;
//   only the decode when no blit is pending
// clear: one byte per cycle over all STORE_BYTES bytes; reset runs the same
//   zeroing pass before the first request is taken
// read: a read result waits in the output register and other requests go on
//   meanwhile, a second read holds until that register frees
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine_core import mfre_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [10:0] in_pos_x,
  input  wire logic signed [10:0] in_pos_y,
  input  wire logic [9:0]         in_width,
  input  wire logic [9:0]         in_height,
  input  wire logic               in_color,
  input  wire logic [2:0]         in_mode,
  input  wire logic [7:0]         in_image_byte,
  input  wire logic [13:0]        in_read_addr,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_read_data
);

  // controller to datapath commands and status
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mfre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memory, clipping, merge and output register
  mfre_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_width      (in_width),
    .in_height     (in_height),
    .in_color      (in_color),
    .in_mode       (in_mode),
    .in_image_byte (in_image_byte),
    .in_read_addr  (in_read_addr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule
`default_nettype wire

[rtl/mfre_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfre_ctrl: command sequencer
// walks clears, rectangles, blit bytes and reads through the datapath
// ----------------------------------------------------------------------------
module mfre_ctrl import mfre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RPREP = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RWR   = 4'd5;
  localparam logic [3:0] S_NSEG  = 4'd6;
  localparam logic [3:0] S_BPREP = 4'd7;
  localparam logic [3:0] S_BA    = 4'd8;
  localparam logic [3:0] S_BWA   = 4'd9;
  localparam logic [3:0] S_BB    = 4'd10;
  localparam logic [3:0] S_BWB   = 4'd11;
  localparam logic [3:0] S_BUPD  = 4'd12;
  localparam logic [3:0] S_RESP  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] seg_r, seg_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.item_cmd)
          CMD_FILL: begin
            cmd.rect_load = 1'b1;
            cmd.seg       = SEG_FULL;
            seg_nxt       = SEG_FULL;
            state_nxt     = S_RPREP;
          end
          CMD_OUTLINE: begin
            cmd.rect_load = 1'b1;
            cmd.seg       = SEG_TOP;
            seg_nxt       = SEG_TOP;
            state_nxt     = S_RPREP;
          end
          CMD_BLIT: begin
            cmd.blit_start = 1'b1;
            state_nxt      = S_IDLE;
          end
          CMD_IMAGE: begin
            state_nxt = stat.blit_pending ? S_BPREP : S_IDLE;
          end
          CMD_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
          CMD_READ: begin
            cmd.mem_rd = 1'b1;
            cmd.src    = SRC_READ;
            state_nxt  = S_RESP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RPREP: begin
        cmd.rect_prep = 1'b1;
        state_nxt     = stat.rect_empty ? S_NSEG : S_RRD;
      end
      S_RRD: begin
        cmd.mem_rd = 1'b1;
        cmd.src    = SRC_RECT;
        state_nxt  = S_RWR;
      end
      S_RWR: begin
        cmd.mem_wr   = 1'b1;
        cmd.src      = SRC_RECT;
        cmd.rect_adv = 1'b1;
        state_nxt    = stat.rect_last ? S_NSEG : S_RRD;
      end
      S_NSEG: begin
        // outline walks top, bottom, left, right
        state_nxt = S_RPREP;
        cmd.rect_load = 1'b1;
        case (seg_r)
          SEG_TOP:  seg_nxt = SEG_BOT;
          SEG_BOT:  seg_nxt = SEG_LEFT;
          SEG_LEFT: seg_nxt = SEG_RIGHT;
          default: begin
            cmd.rect_load = 1'b0;
            state_nxt     = S_IDLE;
          end
        endcase
        cmd.seg = seg_nxt;
      end
      S_BPREP: begin
        cmd.blit_prep = 1'b1;
        state_nxt     = S_BA;
      end
      S_BA: begin
        if (stat.mask_a_nz) begin
          cmd.mem_rd = 1'b1;
          cmd.src    = SRC_BLA;
          state_nxt  = S_BWA;
        end else begin
          state_nxt = S_BB;
        end
      end
      S_BWA: begin
        cmd.mem_wr = 1'b1;
        cmd.src    = SRC_BLA;
        state_nxt  = S_BB;
      end
      S_BB: begin
        if (stat.mask_b_nz) begin
          cmd.mem_rd = 1'b1;
          cmd.src    = SRC_BLB;
          state_nxt  = S_BWB;
        end else begin
          state_nxt = S_BUPD;
        end
      end
      S_BWB: begin
        cmd.mem_wr = 1'b1;
        cmd.src    = SRC_BLB;
        state_nxt  = S_BUPD;
      end
      S_BUPD: begin
        cmd.blit_upd = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      seg_r   <= SEG_FULL;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/mfre_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfre_dpath: framebuffer memory and drawing datapath
// clipping, byte masks, read-modify-write merge, blit state and read-back
// ----------------------------------------------------------------------------
module mfre_dpath import mfre_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [10:0] in_pos_x,
  input  wire logic signed [10:0] in_pos_y,
  input  wire logic [9:0]         in_width,
  input  wire logic [9:0]         in_height,
  input  wire logic               in_color,
  input  wire logic [2:0]         in_mode,
  input  wire logic [7:0]         in_image_byte,
  input  wire logic [13:0]        in_read_addr,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_read_data
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;

  // latched item
  logic [2:0]         cmd_r;
  logic signed [10:0] px_r, py_r;
  logic [9:0]         w_r, h_r;
  logic               color_r;
  logic [2:0]         mode_r;
  logic [7:0]         byte_r;
  logic [13:0]        raddr_r;

  // clipped rectangle and walk
  logic [XW-1:0]  x0_r, x1m1_r;
  logic [YW-1:0]  y0_r, ylast_r, y_r;
  logic           empty_r;
  logic [BXW-1:0] bx_r;
  logic [AW-1:0]  rowbase_r;

  // blit
  logic signed [10:0] box_r, boy_r;
  logic [9:0]         bw_r, bh_r;
  logic [2:0]         bmode_r;
  logic [6:0]         bcol_r;
  logic [9:0]         brow_r;
  logic               bpend_r;
  logic [15:0]        bdat_r, bmsk_r;
  logic [AW-1:0]      baddr_r;

  logic [AW-1:0] clr_addr_r;
  logic [7:0]    clr_byte_r;
  logic          oor_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  // rectangle load
  logic signed [CW-1:0] sx, sy, sw, sh, rx, ry, rw, rh, ex, ey, cx0, cx1, cy0, cy1;
  always_comb begin
    sx = CW'(px_r);
    sy = CW'(py_r);
    sw = $signed(CW'(w_r));
    sh = $signed(CW'(h_r));
    rx = (cmd.seg == SEG_RIGHT) ? sx + sw - CW'(1) : sx;
    ry = (cmd.seg == SEG_BOT) ? sy + sh - CW'(1) : sy;
    rw = (cmd.seg == SEG_LEFT || cmd.seg == SEG_RIGHT) ? CW'(1) : sw;
    rh = (cmd.seg == SEG_TOP || cmd.seg == SEG_BOT) ? CW'(1) : sh;
    ex = rx + rw;
    ey = ry + rh;
    cx0 = (rx < 0) ? '0 : rx;
    cy0 = (ry < 0) ? '0 : ry;
    cx1 = (ex > DRAW_WS) ? DRAW_WS : ex;
    cy1 = (ey > SCREEN_HS) ? SCREEN_HS : ey;
  end

  // rectangle byte mask
  logic [BXW-1:0] bx0, bxe;
  logic [2:0]     lo, hi;
  logic [7:0]     rmask;
  always_comb begin
    bx0 = BXW'(x0_r >> 3);
    bxe = BXW'(x1m1_r >> 3);
    lo  = (bx_r == bx0) ? x0_r[2:0] : 3'd0;
    hi  = (bx_r == bxe) ? x1m1_r[2:0] : 3'd7;
    for (int k = 0; k < 8; k++) begin
      rmask[7-k] = (3'(k) >= lo) && (3'(k) <= hi);
    end
  end

  // blit pixel enables for the current byte
  logic signed [CW-1:0] xs, yy, pxk;
  logic                 yok, pix;
  logic [7:0]           bv, be;
  logic [9:0]           dx;
  always_comb begin
    xs  = CW'(box_r) + $signed(CW'({bcol_r, 3'b000}));
    yy  = CW'(boy_r) + $signed(CW'(brow_r));
    yok = (yy >= 0) && (yy < SCREEN_HS);
    pxk = '0;
    pix = 1'b0;
    dx  = '0;
    for (int k = 0; k < 8; k++) begin
      dx  = {bcol_r, 3'(k)};
      pix = byte_r[7-k];
      pxk = xs + CW'(k);
      bv[7-k] = pix ^ bmode_r[2];
      be[7-k] = (dx < bw_r) && !(bmode_r[0] && pix) && !(bmode_r[1] && !pix)
                && yok && (pxk >= 0) && (pxk < DRAW_WS);
    end
  end

  logic signed [CW-4:0] bbase;
  assign bbase = (CW-3)'(xs >>> 3);

  // memory address, write merge
  logic [AW-1:0] maddr, waddr;
  logic [7:0]    mmask, mdata, wdata;
  always_comb begin
    case (cmd.src)
      SRC_RECT: begin
        maddr = rowbase_r + AW'(bx_r);
        mmask = rmask;
        mdata = {8{color_r}};
      end
      SRC_BLA: begin
        maddr = baddr_r;
        mmask = bmsk_r[15:8];
        mdata = bdat_r[15:8];
      end
      SRC_BLB: begin
        maddr = baddr_r + AW'(1);
        mmask = bmsk_r[7:0];
        mdata = bdat_r[7:0];
      end
      default: begin
        maddr = raddr_r[AW-1:0];
        mmask = '0;
        mdata = '0;
      end
    endcase
    waddr = cmd.clr_step ? clr_addr_r : maddr;
    wdata = cmd.clr_step ? clr_byte_r : ((rdata_r & ~mmask) | (mdata & mmask));
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr || cmd.clr_step) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[maddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      cmd_r   <= in_cmd;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      w_r     <= in_width;
      h_r     <= in_height;
      color_r <= in_color;
      mode_r  <= in_mode;
      byte_r  <= in_image_byte;
      raddr_r <= in_read_addr;
    end
    if (cmd.rect_load) begin
      x0_r    <= XW'(cx0);
      x1m1_r  <= XW'(cx1 - CW'(1));
      y0_r    <= YW'(cy0);
      ylast_r <= YW'(cy1 - CW'(1));
      empty_r <= (cx1 <= cx0) || (cy1 <= cy0);
    end
    if (cmd.rect_prep) begin
      bx_r      <= bx0;
      y_r       <= y0_r;
      rowbase_r <= AW'(y0_r * ROW_BYTES);
    end else if (cmd.rect_adv) begin
      if (bx_r == bxe) begin
        bx_r      <= bx0;
        y_r       <= y_r + YW'(1);
        rowbase_r <= rowbase_r + AW'(ROW_BYTES);
      end else begin
        bx_r <= bx_r + BXW'(1);
      end
    end
    if (cmd.blit_prep) begin
      bdat_r  <= {bv, 8'h00} >> xs[2:0];
      bmsk_r  <= {be, 8'h00} >> xs[2:0];
      baddr_r <= AW'(yy[YW-1:0] * ROW_BYTES) + AW'(bbase);
    end
    if (cmd.mem_rd) oor_r <= (raddr_r >= 14'(STORE_BYTES));
    if (cmd.out_load) out_data_r <= oor_r ? 8'h00 : rdata_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r       <= '0;
      boy_r       <= '0;
      bw_r        <= '0;
      bh_r        <= '0;
      bmode_r     <= '0;
      bcol_r      <= '0;
      brow_r      <= '0;
      bpend_r     <= 1'b0;
      clr_addr_r  <= '0;
      clr_byte_r  <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.blit_start) begin
        box_r   <= px_r;
        boy_r   <= py_r;
        bw_r    <= w_r;
        bh_r    <= h_r;
        bmode_r <= mode_r;
        bcol_r  <= '0;
        brow_r  <= '0;
        bpend_r <= (w_r != '0) && (h_r != '0);
      end else if (cmd.blit_upd) begin
        if ({1'b0, bcol_r} + 8'd1 >= 8'((11'(bw_r) + 11'd7) >> 3)) begin
          bcol_r <= '0;
          brow_r <= brow_r + 10'd1;
          if (11'(brow_r) + 11'd1 >= 11'(bh_r)) bpend_r <= 1'b0;
        end else begin
          bcol_r <= bcol_r + 7'd1;
        end
      end
      if (cmd.clr_start) begin
        clr_addr_r <= '0;
        clr_byte_r <= {8{color_r}};
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.item_cmd     = cmd_r;
    stat.rect_empty   = empty_r;
    stat.rect_last    = (bx_r == bxe) && (y_r == ylast_r);
    stat.clr_last     = (clr_addr_r == AW'(STORE_BYTES - 1));
    stat.blit_pending = bpend_r;
    stat.mask_a_nz    = (bmsk_r[15:8] != 8'h00);
    stat.mask_b_nz    = (bmsk_r[7:0] != 8'h00);
    stat.out_busy     = out_valid_r && out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
`default_nettype wire

[verif/mono_framebuffer_raster_engine_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine_core_tb: self-checking bench of the 1bpp engine
// a driver feeds queued drawing requests with random gaps, a shadow framebuffer
// predicts every read-back byte, and a monitor with random stalls checks them
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine_core_tb;
  import mfre_pkg::*;

  // codes the engine ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 2 * STORE_BYTES + 200;
  localparam int LONG_HOLD    = 600;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [9:0]         w;
    logic [9:0]         h;
    logic               color;
    logic [2:0]         mode;
    logic [7:0]         img;
    logic [13:0]        addr;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic signed [10:0] in_pos_x = '0;
  logic signed [10:0] in_pos_y = '0;
  logic [9:0] in_width = '0;
  logic [9:0] in_height = '0;
  logic in_color = 1'b0;
  logic [2:0] in_mode = '0;
  logic [7:0] in_image_byte = '0;
  logic [13:0] in_read_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;

  mono_framebuffer_raster_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_width(in_width), .in_height(in_height), .in_color(in_color),
    .in_mode(in_mode), .in_image_byte(in_image_byte), .in_read_addr(in_read_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow framebuffer and blit tracking
  logic [7:0] shadow_fb [STORE_BYTES];
  int          bl_x, bl_y, bl_w, bl_h, bl_col, bl_row;
  logic [2:0]  bl_mode;
  bit          bl_active;

  req_t       pending_reqs [$];
  logic [7:0] expected_bytes [$];
  int         fail_count = 0;
  int         accepted = 0;
  int         cycles = 0;
  bit         burst_mode = 0;

  // ---------------------------------------------------------------------------
  // pixel level prediction
  // ---------------------------------------------------------------------------
  function automatic void plot(int x, int y, bit c);
    int idx;
    if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
    if ((x >> 3) >= ROW_BYTES) return;
    idx = y * ROW_BYTES + (x >> 3);
    shadow_fb[idx][7 - (x & 7)] = c;
  endfunction

  function automatic void apply_request(req_t r);
    int x, y, w, h, x0, y0, x1, y1, dx;
    bit pix;
    x = int'(r.x);
    y = int'(r.y);
    w = int'(r.w);
    h = int'(r.h);
    case (r.cmd)
      CMD_FILL: begin
        x0 = x < 0 ? 0 : x;
        y0 = y < 0 ? 0 : y;
        x1 = x + w > SCREEN_W ? SCREEN_W : x + w;
        y1 = y + h > SCREEN_H ? SCREEN_H : y + h;
        for (int py = y0; py < y1; py++)
          for (int px = x0; px < x1; px++) plot(px, py, r.color);
      end
      CMD_OUTLINE: begin
        // sides run over the height, corners may land left of or above origin
        for (int px = x; px < x + w; px++) begin
          plot(px, y, r.color);
          plot(px, y + h - 1, r.color);
        end
        for (int py = y; py < y + h; py++) begin
          plot(x, py, r.color);
          plot(x + w - 1, py, r.color);
        end
      end
      CMD_BLIT: begin
        bl_x = x; bl_y = y; bl_w = w; bl_h = h;
        bl_mode = r.mode; bl_col = 0; bl_row = 0;
        bl_active = (w > 0 && h > 0);
      end
      CMD_IMAGE: begin
        // stray bytes with nothing pending fall through
        if (bl_active) begin
          for (int k = 0; k < 8; k++) begin
            dx = bl_col * 8 + k;
            if (dx >= bl_w) break;
            pix = r.img[7 - k];
            if ((bl_mode[0] && pix) || (bl_mode[1] && !pix)) continue;
            if (bl_mode[2]) pix = !pix;
            plot(bl_x + dx, bl_y + bl_row, pix);
          end
          bl_col++;
          if (bl_col >= (bl_w + 7) / 8) begin
            bl_col = 0;
            bl_row++;
            if (bl_row >= bl_h) bl_active = 0;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = {8{r.color}};
      end
      CMD_READ: begin
        expected_bytes.push_back(r.addr < STORE_BYTES ? shadow_fb[r.addr] : 8'h00);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request builders, unused fields carry random junk
  // ---------------------------------------------------------------------------
  function automatic req_t junk_req();
    req_t r;
    r.cmd = 3'($urandom); r.x = 11'($urandom); r.y = 11'($urandom);
    r.w = 10'($urandom); r.h = 10'($urandom); r.color = 1'($urandom);
    r.mode = 3'($urandom); r.img = 8'($urandom); r.addr = 14'($urandom);
    return r;
  endfunction

  function automatic void push_rect(logic [2:0] cmd, int x, int y, int w, int h, bit c);
    req_t r;
    r = junk_req();
    r.cmd = cmd; r.x = 11'(x); r.y = 11'(y); r.w = 10'(w); r.h = 10'(h); r.color = c;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_read(int addr);
    req_t r;
    r = junk_req();
    r.cmd = CMD_READ; r.addr = 14'(addr);
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_blit(int x, int y, int w, int h, logic [2:0] m);
    req_t r;
    r = junk_req();
    r.cmd = CMD_BLIT; r.x = 11'(x); r.y = 11'(y); r.w = 10'(w); r.h = 10'(h); r.mode = m;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_image(int n, bit mix_reads);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = junk_req();
      r.cmd = CMD_IMAGE;
      pending_reqs.push_back(r);
      if (mix_reads && $urandom_range(0, 5) == 0) push_read($urandom_range(0, 1500));
    end
  endfunction

  function automatic void push_cmd(logic [2:0] cmd, bit c);
    req_t r;
    r = junk_req();
    r.cmd = cmd; r.color = c;
    pending_reqs.push_back(r);
  endfunction

  // reads mostly where the small drawings land
  function automatic int pick_addr();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return $urandom_range(0, 1500);
    if (sel < 19) return $urandom_range(0, STORE_BYTES - 1);
    return $urandom_range(0, 16383);
  endfunction

  function automatic void build_directed();
    push_rect(CMD_FILL, -700, -700, 1023, 1023, 1);     // whole screen, clipped origin
    push_read(0); push_read(STORE_BYTES - 1);
    push_read(STORE_BYTES); push_read(16383);           // past the end reads zero
    push_cmd(CMD_CLEAR, 0);
    push_rect(CMD_OUTLINE, 5, 5, 0, 0, 1);              // zero size outline
    push_rect(CMD_OUTLINE, 20, 3, 0, 3, 1);
    push_rect(CMD_OUTLINE, 1023, 1023, 1023, 1023, 1);  // fully off screen
    push_rect(CMD_OUTLINE, 236, 2, 10, 4, 1);           // right edge clip
    push_read(30 * 3 + 29); push_read(2); push_read(62);
    for (int m = 0; m < 8; m++) begin
      push_blit(-3 + 12 * m, 8, 10, 2, 3'(m));          // padding bits and every mode
      push_image(4, 0);
      push_read(8 * 30 + m); push_read(9 * 30 + m + 1);
    end
    push_blit(0, 0, 0, 5, 0);                           // empty blit
    push_image(1, 0);                                   // stray byte
    push_blit(0, 20, 16, 3, 0);
    push_image(2, 0);
    push_blit(4, 24, 8, 1, 4);                          // replaces the pending one
    push_image(3, 0);
    push_cmd(CMD_SPARE_A, 1); push_cmd(CMD_SPARE_B, 0);
    push_read(20 * 30); push_read(24 * 30);
    push_cmd(CMD_CLEAR, 1);
    push_read(pick_addr());
  endfunction

  function automatic void build_random();
    int sel, w, h, n;
    while (pending_reqs.size() < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        w = $urandom_range(1, 30);
        h = $urandom_range(1, 6);
        push_blit($urandom_range(0, 127) - 20, $urandom_range(0, 47) - 6, w, h,
                  3'($urandom));
        n = ((w + 7) / 8) * h;
        // some sequences cut short, some overrun
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n + 3);
        push_image(n, 1);
      end else if (sel < 65) begin
        push_read(pick_addr());
      end else if (sel < 80) begin
        push_rect(CMD_FILL, $urandom_range(0, 127) - 20, $urandom_range(0, 47) - 6,
                  $urandom_range(0, 40), $urandom_range(0, 12), 1'($urandom));
      end else if (sel < 90) begin
        push_rect(CMD_OUTLINE, $urandom_range(0, 127) - 20, $urandom_range(0, 47) - 6,
                  $urandom_range(0, 40), $urandom_range(0, 12), 1'($urandom));
      end else if (sel < 94) begin
        // wide and clipped, a few rows only
        push_rect($urandom_range(0, 1) ? CMD_FILL : CMD_OUTLINE,
                  $urandom_range(0, 2047) - 1024, $urandom_range(0, 60) - 10,
                  $urandom_range(0, 1023), $urandom_range(0, 3), 1'($urandom));
      end else if (sel < 98) begin
        push_cmd($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, 1'($urandom));
        push_image(1, 0);
      end else if (sel < 99) begin
        push_cmd(CMD_CLEAR, 1'($urandom));
      end else begin
        push_rect(CMD_FILL, $urandom_range(0, 60) - 30, $urandom_range(0, 100) - 30,
                  $urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom));
      end
    end
  endfunction

  function automatic int draw_wait();
    if (burst_mode) return 0;
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: presents the queue head, predicts on acceptance
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  req_t cur_req;

  always @(posedge clk) begin
    int gap_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      gap_next = in_gap;
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
        accepted++;
        if (accepted % 80 == 0) burst_mode = !burst_mode;  // stretches without gaps
        gap_next = draw_wait();
      end
      if (!in_valid || !in_stall) begin
        if (gap_next == 0 && pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_pos_x <= cur_req.x;
          in_pos_y <= cur_req.y;
          in_width <= cur_req.w;
          in_height <= cur_req.h;
          in_color <= cur_req.color;
          in_mode <= cur_req.mode;
          in_image_byte <= cur_req.img;
          in_read_addr <= cur_req.addr;
        end else begin
          in_valid <= 1'b0;
          if (gap_next > 0) gap_next--;
        end
      end
      in_gap = gap_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random stalls plus one long hold to back up the input
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  long_hold_done = 0;

  always @(posedge clk) begin
    logic [7:0] want;
    int hold_next;
    hold_next = hold_left;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected read_data %0h", out_read_data);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_read_data !== want) begin
          $error("read_data expected %0h actual %0h", want, out_read_data);
          fail_count++;
        end
      end
      hold_next = burst_mode ? 0 : $urandom_range(0, 16);
    end
    if (!long_hold_done && accepted >= 200) begin
      long_hold_done = 1;
      hold_next = LONG_HOLD;
    end
    if (hold_next > 0) begin
      out_stall <= 1'b1;
      hold_next--;
    end else begin
      out_stall <= 1'b0;
    end
    hold_left = hold_next;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = 8'h00;
    bl_x = 0; bl_y = 0; bl_w = 0; bl_h = 0; bl_col = 0; bl_row = 0;
    bl_mode = '0; bl_active = 0;
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // everything accepted, then every read answered, then let the last draw finish
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && !out_valid) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

[mono_framebuffer_raster_engine_core.f]
rtl/mfre_pkg.sv
rtl/mfre_ctrl.sv
rtl/mfre_dpath.sv
rtl/mono_framebuffer_raster_engine_core.sv
verif/mono_framebuffer_raster_engine_core_tb.sv
